// ----- design/rpfl_pkg.sv -----
// ----------------------------------------------------------------------------
// rpfl_pkg
// Shared types, codes and sizes of the random page free-list allocator.
// ----------------------------------------------------------------------------
package rpfl_pkg;

    localparam int PAGE_SLOTS = 256;
    localparam int LOG_DEPTH  = 512;
    localparam int SLOT_W     = $clog2(PAGE_SLOTS);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int LOG_W      = $clog2(LOG_DEPTH);
    localparam int PN_W       = 20;
    localparam int RAND_W     = 31;
    localparam int AGE_W      = 9;

    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(PAGE_SLOTS);

    localparam logic [1:0] OP_FREE  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_NOPAGE  = 2'd2;
    localparam logic [1:0] ST_NOLOG   = 2'd3;

    localparam logic CFG_HEAP_START = 1'b0;
    localparam logic CFG_MEM_TOP    = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [31:0]       page_address;
        logic [RAND_W-1:0] rand_value;
        logic [AGE_W-1:0]  log_age;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_address;
        logic [8:0]  free_pages;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // capture input item, start
        logic mod_step;    // one restoring-division step
        logic walk_step;   // advance one link
        logic fetch;       // issue reads of current slot
        logic commit;      // apply the update and build the result
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic mod_done;
        logic walk_done;
        logic is_alloc;
        logic alloc_ok;
    } sts_t;

endpackage

// ----- design/rpfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpfl_ctrl
// Sequencer: load, divide, walk the list, fetch, commit, deliver.
// ----------------------------------------------------------------------------
module rpfl_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  rpfl_pkg::sts_t sts,
    output rpfl_pkg::cmd_t cmd
);
    import rpfl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOD   = 6'b000010,
        S_WALK  = 6'b000100,
        S_FETCH = 6'b001000,
        S_COMIT = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                if (!sts.is_alloc || !sts.alloc_ok) begin
                    state_next = S_FETCH;
                end else if (sts.mod_done) begin
                    state_next = S_WALK;
                end else begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_WALK: begin
                if (sts.walk_done) begin
                    state_next = S_FETCH;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_FETCH: begin
                cmd.fetch = 1'b1;
                state_next = S_COMIT;
            end
            S_COMIT: begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/rpfl_datapath.sv -----
// ----------------------------------------------------------------------------
// rpfl_datapath
// Link, page and log memories, serial modulo, list walker and result build.
// ----------------------------------------------------------------------------
module rpfl_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  rpfl_pkg::in_item_t  s_item,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    input  rpfl_pkg::cmd_t      cmd,
    output rpfl_pkg::sts_t      sts,
    output rpfl_pkg::out_item_t m_item
);
    import rpfl_pkg::*;

    localparam int MOD_STEPS = RAND_W;
    localparam int MCNT_W    = $clog2(MOD_STEPS + 1);

    logic [LINK_W-1:0] next_link [PAGE_SLOTS];
    logic [PN_W-1:0]   slot_page [PAGE_SLOTS];
    logic [PN_W-1:0]   alloc_log [LOG_DEPTH];

    logic [31:0]       heap_start_reg, mem_top_reg;
    in_item_t          item_reg;
    logic [LINK_W-1:0] list_head_reg, spare_head_reg, prev_reg, cur_reg;
    logic [LINK_W-1:0] cur_link_reg;
    logic [PN_W-1:0]   cur_page_reg;
    logic [LINK_W-1:0] spare_link_reg;
    logic [LINK_W:0]   fresh_reg;
    logic [8:0]        free_total_reg;
    logic [31:0]       alloc_total_reg;
    logic [PN_W-1:0]   log_rd_reg;
    logic [8:0]        rem_reg, pos_reg;
    logic [RAND_W-1:0] quo_reg;
    logic [MCNT_W-1:0] mcnt_reg;
    out_item_t         out_reg;
    logic [LINK_W-1:0] walk_nx_reg;
    logic              walk_primed_reg;

    logic [9:0] rem_sh;
    logic [31:0] log_idx;
    logic [31:0] addr;
    logic        free_ok, log_ok;
    logic [LINK_W-1:0] new_slot;
    logic              slot_avail;
    logic [1:0]        res_status;
    logic [31:0]       res_address;
    logic [8:0]        res_free;

    assign addr    = item_reg.page_address;
    assign rem_sh  = {rem_reg, quo_reg[RAND_W-1]};
    assign log_idx = alloc_total_reg - 32'd1 - 32'(item_reg.log_age);
    assign log_ok  = (32'(item_reg.log_age) < alloc_total_reg) &&
                     (32'(item_reg.log_age) < 32'(LOG_DEPTH));
    assign slot_avail = (spare_head_reg != NO_SLOT) || (fresh_reg < (LINK_W+1)'(PAGE_SLOTS));
    assign new_slot   = (spare_head_reg != NO_SLOT) ? spare_head_reg
                                                    : fresh_reg[LINK_W-1:0];
    assign free_ok = (addr[11:0] == 12'd0) && (addr >= heap_start_reg) &&
                     (addr < mem_top_reg) && (free_total_reg < 9'(PAGE_SLOTS)) &&
                     slot_avail;

    assign sts.is_alloc  = (item_reg.op == OP_ALLOC);
    assign sts.alloc_ok  = (free_total_reg != 9'd0) && (list_head_reg != NO_SLOT);
    assign sts.mod_done  = (mcnt_reg == MCNT_W'(MOD_STEPS));
    // Walk ends when position reached or the next link is null.
    assign sts.walk_done = walk_primed_reg &&
                           ((pos_reg == 9'd0) || (walk_nx_reg == NO_SLOT));
    assign m_item = out_reg;

    always_comb begin
        res_status  = ST_OK;
        res_address = '0;
        res_free    = free_total_reg;
        case (item_reg.op)
            OP_FREE: begin
                if (free_ok) begin
                    res_free = free_total_reg + 9'd1;
                end else begin
                    res_status = ST_BAD;
                end
            end
            OP_ALLOC: begin
                if (sts.alloc_ok) begin
                    res_address = {cur_page_reg, 12'd0};
                    res_free    = free_total_reg - 9'd1;
                end else begin
                    res_status = ST_NOPAGE;
                end
            end
            OP_READ: begin
                if (log_ok) begin
                    res_address = {log_rd_reg, 12'd0};
                end else begin
                    res_status = ST_NOLOG;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_start_reg <= '0;
            mem_top_reg    <= 32'd234881024;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HEAP_START: heap_start_reg <= cfg_data;
                CFG_MEM_TOP:    mem_top_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Memory reads, registered.
    always_ff @(posedge aclk) begin
        walk_nx_reg    <= next_link[cur_reg[SLOT_W-1:0]];
        cur_link_reg   <= next_link[cur_reg[SLOT_W-1:0]];
        cur_page_reg   <= slot_page[cur_reg[SLOT_W-1:0]];
        spare_link_reg <= next_link[spare_head_reg[SLOT_W-1:0]];
        log_rd_reg     <= alloc_log[log_idx[LOG_W-1:0]];
    end

    // Memory writes.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            case (item_reg.op)
                OP_FREE: begin
                    if (free_ok) begin
                        slot_page[new_slot[SLOT_W-1:0]] <= addr[31:12];
                        next_link[new_slot[SLOT_W-1:0]] <= list_head_reg;
                    end
                end
                OP_ALLOC: begin
                    if (sts.alloc_ok) begin
                        if (prev_reg != NO_SLOT) begin
                            next_link[prev_reg[SLOT_W-1:0]] <= cur_link_reg;
                        end
                        alloc_log[alloc_total_reg[LOG_W-1:0]] <= cur_page_reg;
                    end
                end
                default: ;
            endcase
        end else if (cmd.fetch && item_reg.op == OP_ALLOC && sts.alloc_ok) begin
            // Return the slot to the spare chain; its old link was read already.
            next_link[cur_reg[SLOT_W-1:0]] <= spare_head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
        end
        if (cmd.load) begin
            quo_reg  <= s_item.rand_value;
            rem_reg  <= '0;
            cur_reg  <= list_head_reg;
            prev_reg <= NO_SLOT;
            walk_primed_reg <= 1'b0;
        end else if (cmd.mod_step) begin
            quo_reg <= {quo_reg[RAND_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, free_total_reg}) begin
                rem_reg <= 9'(rem_sh - {1'b0, free_total_reg});
            end else begin
                rem_reg <= rem_sh[8:0];
            end
        end else if (cmd.walk_step) begin
            if (!walk_primed_reg) begin
                walk_primed_reg <= 1'b1;   // wait for link read of cur
            end else begin
                prev_reg <= cur_reg;
                cur_reg  <= walk_nx_reg;
                pos_reg  <= pos_reg - 9'd1;
                walk_primed_reg <= 1'b0;
            end
        end
        if (cmd.mod_step && mcnt_reg == MCNT_W'(MOD_STEPS - 1)) begin
            pos_reg <= (rem_sh >= {1'b0, free_total_reg}) ?
                       9'(rem_sh - {1'b0, free_total_reg}) : rem_sh[8:0];
        end
        if (cmd.commit) begin
            out_reg.status         <= res_status;
            out_reg.result_address <= res_address;
            out_reg.free_pages     <= res_free;
        end
    end

    // Control state of the list.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcnt_reg        <= '0;
            list_head_reg   <= NO_SLOT;
            spare_head_reg  <= NO_SLOT;
            fresh_reg       <= '0;
            free_total_reg  <= '0;
            alloc_total_reg <= '0;
        end else begin
            if (cmd.load) begin
                mcnt_reg <= '0;
            end else if (cmd.mod_step) begin
                mcnt_reg <= mcnt_reg + MCNT_W'(1);
            end
            if (cmd.commit) begin
                case (item_reg.op)
                    OP_FREE: begin
                        if (free_ok) begin
                            list_head_reg  <= new_slot;
                            free_total_reg <= free_total_reg + 9'd1;
                            if (spare_head_reg != NO_SLOT) begin
                                spare_head_reg <= spare_link_reg;
                            end else begin
                                fresh_reg <= fresh_reg + (LINK_W+1)'(1);
                            end
                        end
                    end
                    OP_ALLOC: begin
                        if (sts.alloc_ok) begin
                            if (prev_reg == NO_SLOT) begin
                                list_head_reg <= cur_link_reg;
                            end
                            spare_head_reg  <= cur_reg;
                            free_total_reg  <= free_total_reg - 9'd1;
                            alloc_total_reg <= alloc_total_reg + 32'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- design/random_page_free_list_allocator_unit.sv -----
// Sequence: free, read-log and allocate from an empty list pass from accept
// through the modulo state, fetch and commit to result valid; allocate also
// runs the 31-step serial modulo and walks to list position P (rand mod free
// count), with one link read per walk step.
// Throughput: one request at a time; next request accepted after result taken.
// Reset: synchronous, active low; list empty, log empty, registers to defaults.
// ----------------------------------------------------------------------------
// random_page_free_list_allocator_unit
// Page free-list allocator with random pick and ring allocation log.
// ----------------------------------------------------------------------------
module random_page_free_list_allocator_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rpfl_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rpfl_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);
    import rpfl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence each request through divide, walk, fetch and commit.
    rpfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold the memories, list pointers and the result register.
    rpfl_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_item    (m_data)
    );

endmodule
